// File: hw/rtl/ekhs_pkg.sv
// ----------------------------------------------------------------------------
// ekhs_pkg
// Shared constants for the edge key hash set: command and outcome codes,
// finaliser constants and field widths.
// ----------------------------------------------------------------------------
package ekhs_pkg;

  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int NODE_W          = 32;
  localparam int KEY_W           = 64;
  localparam int CNT_W           = 11;
  localparam int MIX_SHIFT       = 33;

  localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [1:0] CMD_CONTAINS = 2'd0;
  localparam logic [1:0] CMD_INSERT   = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  localparam logic [1:0] OUT_ABSENT   = 2'd0;
  localparam logic [1:0] OUT_PRESENT  = 2'd1;
  localparam logic [1:0] OUT_INSERTED = 2'd2;
  localparam logic [1:0] OUT_FULL     = 2'd3;

endpackage

// File: hw/rtl/edge_key_hash_set.sv
// The item is taken and hashed on the shared multiplier; each probe reads
// the table memory's read port and then compares the slot, and the result
// goes to the output register. A clear sweeps every slot of the table.
// One item is processed at a time; the next is taken once the last result is
// registered. After reset a sweep empties every slot of the table and
// no item is accepted meanwhile; configuration writes are always taken.
// ----------------------------------------------------------------------------
// edge_key_hash_set
// Edge set in an open-addressing table with linear probing; the packed node
// pair plus one is the key and its 64-bit finaliser picks the first slot.
// ----------------------------------------------------------------------------
module edge_key_hash_set #(
  parameter int TABLE_SLOTS = ekhs_pkg::TABLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,     // undirected_off
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // from_node [31:0], to_node [63:32]
  input  logic [1:0]  in_tuser,     // cmd [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata     // outcome [1:0], entry_count [12:2], zeros
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int KW    = ekhs_pkg::KEY_W;
  localparam int CW    = ekhs_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CMP,
    S_RESP
  } state_t;

  state_t              state_r;
  logic                undir_off_r;
  logic [1:0]          cmd_r;
  logic [KW-1:0]       key_r;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    probe_r;
  logic [IDX_W-1:0]    clr_idx_r;
  logic                clr_resp_r;
  logic [CW-1:0]       cnt_r;
  logic [1:0]          outcome_r;
  logic                out_valid_r;
  logic [15:0]         out_data_r;

  logic [KW:0]         mem [TABLE_SLOTS];
  logic [KW:0]         rd_q_r;

  logic                in_acc;
  logic [31:0]         node_a;
  logic [31:0]         node_b;
  logic [KW-1:0]       in_key;
  logic                hash_start;
  logic                hash_done;
  logic [KW-1:0]       hash_val;
  logic                slot_hit;
  logic                slot_empty;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [KW:0]         mem_wdata;
  logic                mem_re;
  logic                out_free;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    node_a = in_tdata[31:0];
    node_b = in_tdata[63:32];
    if (!undir_off_r && (in_tdata[63:32] < in_tdata[31:0])) begin
      node_a = in_tdata[63:32];
      node_b = in_tdata[31:0];
    end
    in_key     = {node_a, node_b} + KW'(1);
    hash_start = in_acc && (in_tuser == ekhs_pkg::CMD_CONTAINS ||
                            in_tuser == ekhs_pkg::CMD_INSERT);
  end

  ekhs_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_key),
    .done  (hash_done),
    .hash  (hash_val)
  );

  always_comb begin
    slot_hit   = rd_q_r[KW] && (rd_q_r[KW-1:0] == key_r);
    slot_empty = !rd_q_r[KW];
    mem_re     = (state_r == S_READ);
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = {1'b1, key_r};
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (state_r == S_CMP && slot_empty && cmd_r == ekhs_pkg::CMD_INSERT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      undir_off_r <= 1'b0;
      clr_idx_r   <= '0;
      clr_resp_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        undir_off_r <= cfg_data;
      end
      if (out_valid_r && out_tready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (clr_idx_r == '1) begin
            state_r <= clr_resp_r ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd_r     <= in_tuser;
            key_r     <= in_key;
            outcome_r <= ekhs_pkg::OUT_ABSENT;
            if (hash_start) begin
              state_r <= S_HASH;
            end else if (in_tuser == ekhs_pkg::CMD_CLEAR) begin
              cnt_r      <= '0;
              clr_idx_r  <= '0;
              clr_resp_r <= 1'b1;
              state_r    <= S_CLEAR;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx_r   <= hash_val[IDX_W-1:0];
            probe_r <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (slot_hit) begin
            outcome_r <= ekhs_pkg::OUT_PRESENT;
            state_r   <= S_RESP;
          end else if (slot_empty) begin
            if (cmd_r == ekhs_pkg::CMD_INSERT) begin
              outcome_r <= ekhs_pkg::OUT_INSERTED;
              cnt_r     <= cnt_r + CW'(1);
            end
            state_r <= S_RESP;
          end else if (probe_r == '1) begin
            outcome_r <= (cmd_r == ekhs_pkg::CMD_INSERT) ? ekhs_pkg::OUT_FULL
                                                         : ekhs_pkg::OUT_ABSENT;
            state_r   <= S_RESP;
          end else begin
            probe_r <= probe_r + IDX_W'(1);
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_READ;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'b000, cnt_r, outcome_r};
            clr_resp_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result registered outside the response state");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_CMP) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("slot written without the entry count advancing");

  a_hash_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == S_HASH))
    else $error("hash finished while no lookup was waiting for it");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP || state_r == S_CLEAR) |-> !in_tready)
    else $error("input taken while a probe or sweep is in progress");

endmodule

// File: hw/rtl/ekhs_mix.sv
// ----------------------------------------------------------------------------
// ekhs_mix
// Iterative 64-bit finaliser: each wrapping 64-bit multiply is built from
// three 32 by 32 partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module ekhs_mix (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ekhs_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [ekhs_pkg::KEY_W-1:0] hash
);

  typedef enum logic [1:0] {
    ST_LL,
    ST_LH,
    ST_HL,
    ST_XOR
  } step_t;

  step_t                       step_r;
  logic                        busy_r;
  logic                        round_r;
  logic                        done_r;
  logic [ekhs_pkg::KEY_W-1:0]  v_r;
  logic [ekhs_pkg::KEY_W-1:0]  acc_r;

  logic [ekhs_pkg::KEY_W-1:0]  mconst;
  logic [31:0]                 opa;
  logic [31:0]                 opb;
  logic [63:0]                 prod;

  always_comb begin
    mconst = round_r ? ekhs_pkg::MIX_C2 : ekhs_pkg::MIX_C1;
    opa    = (step_r == ST_HL) ? v_r[63:32] : v_r[31:0];
    opb    = (step_r == ST_LH) ? mconst[63:32] : mconst[31:0];
    prod   = 64'(opa) * 64'(opb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      round_r <= 1'b0;
      step_r  <= ST_LL;
    end else begin
      done_r <= busy_r && !start && round_r && (step_r == ST_XOR);
      if (start) begin
        busy_r  <= 1'b1;
        round_r <= 1'b0;
        step_r  <= ST_LL;
        v_r     <= key ^ (key >> ekhs_pkg::MIX_SHIFT);
      end else if (busy_r) begin
        case (step_r)
          ST_LL: begin
            acc_r  <= prod;
            step_r <= ST_LH;
          end
          ST_LH: begin
            acc_r[63:32] <= acc_r[63:32] + prod[31:0];
            step_r       <= ST_HL;
          end
          ST_HL: begin
            acc_r[63:32] <= acc_r[63:32] + prod[31:0];
            step_r       <= ST_XOR;
          end
          default: begin
            v_r    <= acc_r ^ (acc_r >> ekhs_pkg::MIX_SHIFT);
            step_r <= ST_LL;
            if (round_r) begin
              busy_r <= 1'b0;
            end else begin
              round_r <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign done = done_r;
  assign hash = v_r;

endmodule
